// ===== design/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types for the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none
package gbs_pkg;
  localparam int MAX_CANDIDATES = 1024;
  localparam int ADDR_W = $clog2(MAX_CANDIDATES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int BOX_W = 4 * COORD_W;
  localparam int DATA_W = BOX_W + SCORE_W;
  localparam int ENTRY_W = DATA_W + 1;
  localparam int THR_W = 16;
  localparam int KEPT_W = 7;
  localparam logic [KEPT_W-1:0] KEPT_MAX = 7'd64;
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
  localparam logic [KEPT_W-1:0] KEPT_RESET = 7'd16;
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_MAX_KEPT = 1'b1;

  typedef logic [ENTRY_W-1:0] entry_t;
endpackage
`default_nettype wire

// ===== design/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression over one frame of boxes held in a memory.
// ----------------------------------------------------------------------------
// Loading takes one candidate per cycle into the candidate memory.
// After the final candidate, each kept box costs a selection scan, a pick
// step, an emit step and a suppression scan over the single read port, and
// output stalls add to this before loading resumes.
// Reset is synchronous, clears the frame count and flags and loads the default settings.
`default_nettype none
module greedy_box_suppression (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // left, top, right, bottom, score
  input  wire logic        s_tlast,   // final_candidate
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // kept_left, kept_top, kept_right, kept_bottom, kept_score
  output logic             m_tlast,   // last_kept
  output logic             m_tuser,   // dropped_overflow
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  typedef enum logic [2:0] {LOAD, SEL, PICK, EMIT, SUP, FLUSH} state_t;

  state_t state;
  gbs_pkg::entry_t mem [gbs_pkg::MAX_CANDIDATES];
  gbs_pkg::entry_t mem_q;
  logic [gbs_pkg::CNT_W-1:0] count, cnt;
  logic overflow;
  logic [gbs_pkg::THR_W-1:0] thr;
  logic [gbs_pkg::KEPT_W-1:0] max_kept, limit, kept;
  logic rd_en, we;
  logic [gbs_pkg::ADDR_W-1:0] wa;
  gbs_pkg::entry_t wd;
  logic found, have_pend;
  gbs_pkg::entry_t sel, pend;
  logic [gbs_pkg::ADDR_W-1:0] sel_idx, idx1, idx2, idx3, idx4;
  logic v1, v2, v3, v4;
  gbs_pkg::entry_t d2, d3, d4;
  logic signed [33:0] area_a;
  logic signed [16:0] iw, ih, bw, bh;
  logic ne2, ne3, ok4;
  logic signed [33:0] inter3, ab3;
  logic [31:0] inter4;
  logic [34:0] uni4;
  logic [15:0] x1, y1, x2, y2;
  logic signed [35:0] uni_c;
  logic [50:0] prod;
  logic hit, scanning, out_free;
  logic [gbs_pkg::KEPT_W-1:0] kept_inc;

  assign s_tready = (state == LOAD);
  assign cfg_ready = 1'b1;
  assign scanning = (state == SEL) || (state == SUP);
  assign rd_en = scanning && (cnt < count);
  assign out_free = !m_tvalid || m_tready;
  assign kept_inc = kept + 7'd1;

  always_comb begin
    x1 = (mem_q[15:0] > sel[15:0]) ? mem_q[15:0] : sel[15:0];
    y1 = (mem_q[31:16] > sel[31:16]) ? mem_q[31:16] : sel[31:16];
    x2 = (mem_q[47:32] < sel[47:32]) ? mem_q[47:32] : sel[47:32];
    y2 = (mem_q[63:48] < sel[63:48]) ? mem_q[63:48] : sel[63:48];
    uni_c = 36'(area_a) + 36'(ab3) - 36'(inter3);
    prod = 51'(thr) * 51'(uni4);
    hit = ok4 && ({3'b000, inter4, 16'h0000} > prod);
  end

  always_comb begin
    we = 1'b0;
    wa = count[gbs_pkg::ADDR_W-1:0];
    wd = {1'b0, s_tdata};
    if (state == LOAD) begin
      we = s_tvalid && (count < gbs_pkg::CNT_W'(gbs_pkg::MAX_CANDIDATES));
    end else if (v4) begin
      we = 1'b1;
      wa = idx4;
      wd = {d4[gbs_pkg::ENTRY_W-1] | (idx4 == sel_idx) | hit, d4[gbs_pkg::DATA_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      mem_q <= mem[cnt[gbs_pkg::ADDR_W-1:0]];
    end
  end

  // Suppression pipeline: overlap extents, products, union, threshold test.
  always_ff @(posedge clk) begin
    idx2 <= idx1;
    d2 <= mem_q;
    iw <= $signed({1'b0, x2}) - $signed({1'b0, x1});
    ih <= $signed({1'b0, y2}) - $signed({1'b0, y1});
    bw <= $signed({1'b0, mem_q[47:32]}) - $signed({1'b0, mem_q[15:0]});
    bh <= $signed({1'b0, mem_q[63:48]}) - $signed({1'b0, mem_q[31:16]});
    ne2 <= (x2 > x1) && (y2 > y1);
    idx3 <= idx2;
    d3 <= d2;
    inter3 <= 34'(iw) * 34'(ih);
    ab3 <= 34'(bw) * 34'(bh);
    ne3 <= ne2;
    idx4 <= idx3;
    d4 <= d3;
    inter4 <= inter3[31:0];
    uni4 <= uni_c[34:0];
    ok4 <= ne3 && (uni_c > 36'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      cnt <= '0;
      overflow <= 1'b0;
      thr <= gbs_pkg::THR_RESET;
      max_kept <= gbs_pkg::KEPT_RESET;
      limit <= gbs_pkg::KEPT_RESET;
      kept <= '0;
      found <= 1'b0;
      have_pend <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          gbs_pkg::CFG_THRESHOLD: thr <= cfg_data;
          gbs_pkg::CFG_MAX_KEPT:  max_kept <= cfg_data[gbs_pkg::KEPT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != EMIT) && (state != FLUSH)) begin
        m_tvalid <= 1'b0;
      end
      v1 <= rd_en;
      idx1 <= cnt[gbs_pkg::ADDR_W-1:0];
      if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
      v2 <= v1 && (state == SUP);
      v3 <= v2;
      v4 <= v3;
      if (v1 && (state == SEL) && !mem_q[gbs_pkg::ENTRY_W-1] &&
          (!found || (mem_q[79:64] > sel[79:64]))) begin
        found <= 1'b1;
        sel <= mem_q;
        sel_idx <= idx1;
      end
      unique case (state)
        LOAD: begin
          if (s_tvalid) begin
            if (count < gbs_pkg::CNT_W'(gbs_pkg::MAX_CANDIDATES)) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            if (s_tlast) begin
              cnt <= '0;
              found <= 1'b0;
              kept <= '0;
              limit <= (max_kept == '0) ? 7'd1 :
                       (max_kept > gbs_pkg::KEPT_MAX) ? gbs_pkg::KEPT_MAX : max_kept;
              state <= SEL;
            end
          end
        end
        SEL: begin
          if (cnt == count && !v1) begin
            state <= found ? PICK : FLUSH;
          end
        end
        PICK: begin
          area_a <= 34'($signed({1'b0, sel[47:32]}) - $signed({1'b0, sel[15:0]})) *
                    34'($signed({1'b0, sel[63:48]}) - $signed({1'b0, sel[31:16]}));
          cnt <= '0;
          if (have_pend) begin
            state <= EMIT;
          end else begin
            pend <= sel;
            have_pend <= 1'b1;
            kept <= kept_inc;
            state <= (kept_inc == limit) ? FLUSH : SUP;
          end
        end
        EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= pend[gbs_pkg::DATA_W-1:0];
            m_tlast <= 1'b0;
            m_tuser <= overflow;
            pend <= sel;
            kept <= kept_inc;
            state <= (kept_inc == limit) ? FLUSH : SUP;
          end
        end
        SUP: begin
          if (cnt == count && !v1 && !v2 && !v3 && !v4) begin
            cnt <= '0;
            found <= 1'b0;
            state <= SEL;
          end
        end
        FLUSH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= pend[gbs_pkg::DATA_W-1:0];
            m_tlast <= 1'b1;
            m_tuser <= overflow;
            have_pend <= 1'b0;
            count <= '0;
            overflow <= 1'b0;
            state <= LOAD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/gbs_checker.sv =====
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none
module gbs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        cfg_ready
);
  // No result can appear in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The configuration channel never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel stalled");

  // A final candidate that is taken closes loading.
  a_final_stops_load: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during suppression");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");
endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tlast(m_tlast), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for greedy_box_suppression. Candidate boxes stream in, and each
// frame is suppressed by a scoreboard that sorts by score, keeps boxes and
// drops the overlapping ones. Every kept box that comes out is compared with
// the oldest prediction. Directed frames cover extremes, ties, inverted and
// empty boxes, and store overflow. Random frames of clustered boxes follow,
// under several threshold and max_kept settings, with random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] right;
  logic [15:0] bottom;
  logic [15:0] score;
  logic        last_kept;
  logic        overflow;
} kept_box_t;

class nms_scoreboard;
  logic [15:0] corners[gbs_pkg::MAX_CANDIDATES][4];
  logic [15:0] scores[gbs_pkg::MAX_CANDIDATES];
  int          count;
  bit          overflow;
  logic [15:0] threshold = gbs_pkg::THR_RESET;
  logic [6:0]  max_kept = gbs_pkg::KEPT_RESET;
  kept_box_t   kept_q[$];
  int          errors;

  function bit overlaps(int a, int b);
    longint x1, y1, x2, y2, inter, area_a, area_b, uni;
    x1 = (corners[a][0] > corners[b][0]) ? corners[a][0] : corners[b][0];
    y1 = (corners[a][1] > corners[b][1]) ? corners[a][1] : corners[b][1];
    x2 = (corners[a][2] < corners[b][2]) ? corners[a][2] : corners[b][2];
    y2 = (corners[a][3] < corners[b][3]) ? corners[a][3] : corners[b][3];
    if (x2 <= x1 || y2 <= y1) return 0;
    inter = (x2 - x1) * (y2 - y1);
    area_a = (longint'(corners[a][2]) - longint'(corners[a][0])) *
             (longint'(corners[a][3]) - longint'(corners[a][1]));
    area_b = (longint'(corners[b][2]) - longint'(corners[b][0])) *
             (longint'(corners[b][3]) - longint'(corners[b][1]));
    uni = area_a + area_b - inter;
    if (uni <= 0) return 0;
    return inter * 65536 > longint'(threshold) * uni;
  endfunction

  function void note_candidate(logic [79:0] data, logic final_flag);
    int order[$];
    bit taken[gbs_pkg::MAX_CANDIDATES];
    bit gone[gbs_pkg::MAX_CANDIDATES];
    int best, limit, kept;
    kept_box_t k;
    if (count < gbs_pkg::MAX_CANDIDATES) begin
      for (int c = 0; c < 4; c++) corners[count][c] = data[16*c +: 16];
      scores[count] = data[79:64];
      count++;
    end else begin
      overflow = 1;
    end
    if (!final_flag) return;
    for (int n = 0; n < count; n++) begin
      best = -1;
      for (int i = 0; i < count; i++)
        if (!taken[i] && (best < 0 || scores[i] > scores[best])) best = i;
      taken[best] = 1;
      order = {order, best};
    end
    limit = (max_kept < 1) ? 1 : (max_kept > 64) ? 64 : max_kept;
    kept = 0;
    for (int i = 0; i < count && kept < limit; i++) begin
      if (gone[order[i]]) continue;
      k.left = corners[order[i]][0];
      k.top = corners[order[i]][1];
      k.right = corners[order[i]][2];
      k.bottom = corners[order[i]][3];
      k.score = scores[order[i]];
      k.last_kept = 0;
      k.overflow = overflow;
      kept_q = {kept_q, k};
      kept++;
      for (int j = i + 1; j < count; j++)
        if (!gone[order[j]] && overlaps(order[i], order[j])) gone[order[j]] = 1;
    end
    kept_q[kept_q.size() - 1].last_kept = 1;
    count = 0;
    overflow = 0;
  endfunction

  function void check_kept(logic [79:0] data, logic last, logic ovf);
    kept_box_t e;
    if (kept_q.size() == 0) begin
      $error("kept box with no prediction pending: %h", data);
      errors++;
      return;
    end
    e = kept_q.pop_front();
    if (data[15:0] !== e.left) begin
      $error("kept_left expected %0d actual %0d", e.left, data[15:0]); errors++;
    end
    if (data[31:16] !== e.top) begin
      $error("kept_top expected %0d actual %0d", e.top, data[31:16]); errors++;
    end
    if (data[47:32] !== e.right) begin
      $error("kept_right expected %0d actual %0d", e.right, data[47:32]); errors++;
    end
    if (data[63:48] !== e.bottom) begin
      $error("kept_bottom expected %0d actual %0d", e.bottom, data[63:48]); errors++;
    end
    if (data[79:64] !== e.score) begin
      $error("kept_score expected %0d actual %0d", e.score, data[79:64]); errors++;
    end
    if (last !== e.last_kept) begin
      $error("last_kept expected %0d actual %0d", e.last_kept, last); errors++;
    end
    if (ovf !== e.overflow) begin
      $error("dropped_overflow expected %0d actual %0d", e.overflow, ovf); errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = '0;

  nms_scoreboard sb = new();
  bit  no_stall = 0;
  int  cycles = 0;
  int  frame_len = 0;

  greedy_box_suppression u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (m_tvalid && m_tready) sb.check_kept(m_tdata, m_tlast, m_tuser);
  end

  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) begin
        @(negedge clk);
        m_tready = 1;
      end
      if (!no_stall) begin
        run = $urandom_range(1, 12);
        repeat (run) begin
          @(negedge clk);
          m_tready = 0;
        end
      end
    end
  end

  task automatic send_box(input logic [15:0] l, t, r, b, s, input logic fin);
    if (!no_stall && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    s_tvalid = 1;
    s_tdata = {s, b, r, t, l};
    s_tlast = fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_candidate(s_tdata, fin);
    frame_len = fin ? 0 : frame_len + 1;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic drain();
    while (sb.kept_q.size() != 0) @(negedge clk);
    repeat (2 * gbs_pkg::MAX_CANDIDATES + 50) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    drain();
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == gbs_pkg::CFG_THRESHOLD) sb.threshold = value;
    else sb.max_kept = value[6:0];
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Boxes mostly near one of two centers, so that suppression really happens.
  task automatic random_frame(input int len);
    logic [15:0] cx, cy, w, h, l, t, r, b, s;
    for (int i = 0; i < len; i++) begin
      cx = $urandom_range(2000, 30000);
      cy = $urandom_range(2000, 30000);
      if ($urandom_range(0, 2) != 0) begin
        cx = 8000 + 12000 * $urandom_range(0, 1) + $urandom_range(0, 600);
        cy = 10000 + $urandom_range(0, 600);
      end
      w = $urandom_range(100, 4000);
      h = $urandom_range(100, 4000);
      l = cx - w / 2; r = cx + w / 2; t = cy - h / 2; b = cy + h / 2;
      case ($urandom_range(0, 9))
        0: begin l = $urandom; t = $urandom; r = $urandom; b = $urandom; end
        1: begin l = r; r = cx - w; end
        default: ;
      endcase
      s = ($urandom_range(0, 3) == 0) ? 16'(1000 * $urandom_range(0, 3)) : 16'($urandom);
      send_box(l, t, r, b, s, i == len - 1);
    end
  endtask

  initial begin
    int left_items;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Extremes, ties, identical, inverted, zero-area and out-of-range boxes.
    send_box(0, 0, 32768, 32768, 65535, 0);
    send_box(0, 0, 32768, 32768, 65535, 0);
    send_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0);
    send_box(100, 100, 100, 900, 500, 0);
    send_box(30000, 30000, 1000, 1000, 600, 0);
    send_box(1000, 1000, 30000, 30000, 600, 0);
    send_box(16'h5555, 16'haaaa, 16'haaaa, 16'hffff, 16'h5555, 0);
    send_box(16'haaaa, 16'h5555, 16'hffff, 16'haaaa, 16'haaaa, 1);
    send_box(0, 0, 0, 0, 0, 1);
    write_reg(gbs_pkg::CFG_THRESHOLD, 0);
    write_reg(gbs_pkg::CFG_MAX_KEPT, 0);
    send_box(10, 10, 20, 20, 7, 0);
    send_box(10, 10, 20, 20, 9, 0);
    send_box(5000, 5000, 9000, 9000, 8, 1);
    write_reg(gbs_pkg::CFG_MAX_KEPT, 127);
    send_box(10, 10, 20, 20, 7, 0);
    send_box(11, 11, 21, 21, 7, 0);
    send_box(30000, 0, 32768, 2000, 7, 1);

    // A frame that overruns the store, its final candidate dropped as well.
    write_reg(gbs_pkg::CFG_MAX_KEPT, 3);
    write_reg(gbs_pkg::CFG_THRESHOLD, 16'hffff);
    for (int i = 0; i < gbs_pkg::MAX_CANDIDATES + 2; i++)
      send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               i == gbs_pkg::MAX_CANDIDATES + 1);

    write_reg(gbs_pkg::CFG_MAX_KEPT, 64);
    write_reg(gbs_pkg::CFG_THRESHOLD, 29491);
    left_items = 110;
    while (left_items > 0) begin
      run_random: begin
        int len;
        len = $urandom_range(1, 12);
        if (left_items < 30) no_stall = 1;
        random_frame(len);
        left_items -= len;
        case ($urandom_range(0, 5))
          0: write_reg(gbs_pkg::CFG_THRESHOLD, 16'($urandom));
          1: write_reg(gbs_pkg::CFG_MAX_KEPT, 16'($urandom_range(0, 127)));
          2: write_reg(gbs_pkg::CFG_MAX_KEPT, 1);
          3: drain();
          default: ;
        endcase
      end
    end

    drain();
    if (sb.errors == 0 && sb.kept_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
design/gbs_pkg.sv
design/greedy_box_suppression.sv
design/gbs_checker.sv
verif/tb.sv
